FILE: rtl/core/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg
// shared types and constants for the binary32 add/sub unit
// ----------------------------------------------------------------------------
package fas_pkg;
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [30:0] EXP_MASK = 31'h7F80_0000;

    typedef enum logic [1:0] {
        CLS_NORMAL = 2'd0,
        CLS_NAN    = 2'd1,
        CLS_INF    = 2'd2
    } t_cls;

    // classified request handed from front to back
    typedef struct packed {
        t_cls        cls;
        logic        sign;     // sign of larger operand, or of infinity
        logic        eff_sub;
        logic        zero_neg; // both effective operands negative
        logic [7:0]  el;
        logic [26:0] ml;
        logic [26:0] ms;       // aligned, with sticky
    } t_req;
endpackage

FILE: rtl/core/fas_front.sv
// ----------------------------------------------------------------------------
// fas_front
// unpacks, classifies, swaps and aligns one request
// ----------------------------------------------------------------------------
module fas_front (
    input  logic [31:0]   i_a,
    input  logic [31:0]   i_b,
    input  logic          i_mode,
    output fas_pkg::t_req o_req
);
    import fas_pkg::*;

    logic        sa, sb;
    logic [30:0] la, lb, hl, hs;
    logic        sl, ss;
    logic [7:0]  el, es, d;
    logic [26:0] ml, ms, msh, lost_mask;

    always_comb begin
        sa = i_a[31];
        sb = i_b[31] ^ i_mode;
        la = i_a[30:0];
        lb = i_b[30:0];
        if (la >= lb) begin
            hl = la; sl = sa; hs = lb; ss = sb;
        end else begin
            hl = lb; sl = sb; hs = la; ss = sa;
        end
        el = (hl[30:23] == 8'd0) ? 8'd1 : hl[30:23];
        es = (hs[30:23] == 8'd0) ? 8'd1 : hs[30:23];
        ml = {(hl[30:23] != 8'd0), hl[22:0], 3'b000};
        ms = {(hs[30:23] != 8'd0), hs[22:0], 3'b000};
        d  = el - es;
        if (d >= 8'd27) begin
            msh = {26'd0, (ms != 27'd0)};
        end else begin
            lost_mask = ~(27'h7FF_FFFF << d[4:0]);
            msh = (ms >> d[4:0]) | {26'd0, ((ms & lost_mask) != 27'd0)};
        end
        lost_mask = ~(27'h7FF_FFFF << d[4:0]);

        o_req.cls      = CLS_NORMAL;
        o_req.sign     = sl;
        o_req.eff_sub  = sl ^ ss;
        o_req.zero_neg = sa & sb;
        o_req.el       = el;
        o_req.ml       = ml;
        o_req.ms       = msh;
        if (la > EXP_MASK || lb > EXP_MASK) begin
            o_req.cls = CLS_NAN;
        end else if (la == EXP_MASK && lb == EXP_MASK) begin
            o_req.cls  = (sa != sb) ? CLS_NAN : CLS_INF;
            o_req.sign = sa;
        end else if (la == EXP_MASK) begin
            o_req.cls  = CLS_INF;
            o_req.sign = sa;
        end else if (lb == EXP_MASK) begin
            o_req.cls  = CLS_INF;
            o_req.sign = sb;
        end
    end
endmodule

FILE: rtl/core/fas_back.sv
// ----------------------------------------------------------------------------
// fas_back
// adds magnitudes, normalizes, rounds and packs one request
// ----------------------------------------------------------------------------
module fas_back (
    input  fas_pkg::t_req i_req,
    output logic [31:0]   o_result
);
    import fas_pkg::*;

    logic [27:0] r;
    logic [26:0] rn;
    logic [8:0]  e;
    logic [4:0]  lz, sh;
    logic [24:0] mant;
    logic [2:0]  grs;
    logic        found;

    always_comb begin
        r = i_req.eff_sub
            ? ({1'b0, i_req.ml} - {1'b0, i_req.ms})
            : ({1'b0, i_req.ml} + {1'b0, i_req.ms});
        e = {1'b0, i_req.el};
        lz = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found && r[i]) begin
                found = 1'b1;
                lz = 5'(26 - i);
            end
        end
        if (r[27]) begin
            rn = r[27:1] | {26'd0, r[0]};
            e  = e + 9'd1;
        end else begin
            sh = (e - 9'd1 < {4'd0, lz}) ? 5'(e - 9'd1) : lz;
            rn = r[26:0] << sh;
            e  = e - {4'd0, sh};
        end
        grs  = rn[2:0];
        mant = {1'b0, rn[26:3]};
        if (grs[2] && (grs[1] || grs[0] || mant[0]))
            mant = mant + 25'd1;
        if (mant[24]) begin
            mant = mant >> 1;
            e    = e + 9'd1;
        end
        if (!mant[23])
            e = 9'd0;

        case (i_req.cls)
            CLS_NAN: o_result = QNAN;
            CLS_INF: o_result = {i_req.sign, 8'hFF, 23'd0};
            default: begin
                if (r == 28'd0)
                    o_result = {i_req.zero_neg, 31'd0};
                else if (e >= 9'd255)
                    o_result = {i_req.sign, 8'hFF, 23'd0};
                else
                    o_result = {i_req.sign, e[7:0], mant[22:0]};
            end
        endcase
    end
endmodule

FILE: rtl/core/float32_add_sub_unit.sv
// ----------------------------------------------------------------------------
// float32_add_sub_unit
// binary32 adder/subtractor, round to nearest even
// ----------------------------------------------------------------------------
// Takes one request per cycle (busy is always low) and returns the result on
// o_result with o_valid high after it has passed the front (unpack, swap,
// align), the one-entry queue register, the back (add, leading-one normalize,
// round) and the result register. The queue register always drains since the
// receiver cannot stall. NaN inputs give 0x7FC00000.
module float32_add_sub_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic        i_mode,
    output logic        o_valid,
    output logic [31:0] o_result
);
    import fas_pkg::*;

    t_req        n_q, r_q;
    logic        r_qv, r_ov;
    logic [31:0] n_res, r_res;

    assign busy = 1'b0;

    fas_front u_front (
        .i_a    (i_operand_a),
        .i_b    (i_operand_b),
        .i_mode (i_mode),
        .o_req  (n_q)
    );

    fas_back u_back (
        .i_req    (r_q),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_qv <= start && !busy;
            r_ov <= r_qv;
        end
        r_q   <= n_q;
        r_res <= n_res;
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##1 o_valid) else $error("result missing");
    a_nores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(r_qv) |-> !o_valid) else $error("spurious result");
endmodule

FILE: tb/fas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_checker
// predicts and checks the binary32 add/sub results seen on the unit's ports
// ----------------------------------------------------------------------------
// Every accepted request is turned into an expected sum or difference by an
// independent round-to-nearest-even model; each o_valid strobe is compared
// against the oldest pending expectation.
module fas_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    input  logic        i_mode,
    input  logic        o_valid,
    input  logic [31:0] o_result,
    output int          fail_count,
    output int          pending
);
    import fas_pkg::*;

    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] INF_MAG   = 32'h7F80_0000;
    localparam logic [31:0] FRAC_BITS = 32'h007F_FFFF;
    localparam logic [31:0] MAG_BITS  = 32'h7FFF_FFFF;

    logic [31:0] expected_sums[$];

    function automatic logic [31:0] predict_sum(logic [31:0] a, logic [31:0] b,
                                                logic sub);
        logic        sa, sb, big_sign, small_sign, lsb, sticky;
        logic [31:0] mag_a, mag_b, big, little;
        int          eb, es, shift;
        logic [27:0] mb, msm, r;
        logic [24:0] mant;
        logic [2:0]  grs;
        sa    = a[31];
        sb    = b[31] ^ sub;
        mag_a = a & MAG_BITS;
        mag_b = b & MAG_BITS;
        if (mag_a > INF_MAG || mag_b > INF_MAG) return QNAN;
        if (mag_a == INF_MAG && mag_b == INF_MAG)
            return (sa != sb) ? QNAN : ({sa, 31'b0} | INF_MAG);
        if (mag_a == INF_MAG) return {sa, 31'b0} | INF_MAG;
        if (mag_b == INF_MAG) return {sb, 31'b0} | INF_MAG;
        if (mag_a >= mag_b) begin
            big = mag_a; big_sign = sa; little = mag_b; small_sign = sb;
        end else begin
            big = mag_b; big_sign = sb; little = mag_a; small_sign = sa;
        end
        eb  = big[30:23];
        es  = little[30:23];
        mb  = {5'b0, big[22:0]};
        msm = {5'b0, little[22:0]};
        if (eb == 0) eb = 1; else mb[23] = 1'b1;
        if (es == 0) es = 1; else msm[23] = 1'b1;
        mb    = mb << 3;
        msm   = msm << 3;
        shift = eb - es;
        if (shift >= 27) begin
            msm = (msm != 0) ? 28'd1 : 28'd0;
        end else if (shift > 0) begin
            sticky = (msm & ((28'd1 << shift) - 28'd1)) != 0;
            msm    = (msm >> shift) | {27'b0, sticky};
        end
        r = (big_sign != small_sign) ? (mb - msm) : (mb + msm);
        if (r == 0) return (sa & sb) ? SIGN_MASK : 32'h0;
        if (r[27]) begin
            r  = (r >> 1) | {27'b0, r[0]};
            eb = eb + 1;
        end else begin
            while (!r[26] && eb > 1) begin
                r  = r << 1;
                eb = eb - 1;
            end
        end
        grs  = r[2:0];
        mant = r[27:3];
        lsb  = mant[0];
        if (grs[2] && (grs[1:0] != 0 || lsb)) mant = mant + 25'd1;
        if (mant[24]) begin
            mant = mant >> 1;
            eb   = eb + 1;
        end
        if (eb >= 255) return {big_sign, 31'b0} | INF_MAG;
        if (!mant[23]) eb = 0;
        return {big_sign, eb[7:0], mant[22:0] & FRAC_BITS[22:0]};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fail_count <= 0;
            expected_sums.delete();
        end else begin
            if (o_valid) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result 0x%08h", o_result);
                    fail_count <= fail_count + 1;
                end else begin
                    if (o_result !== expected_sums[0]) begin
                        $error("result: expected 0x%08h actual 0x%08h",
                               expected_sums[0], o_result);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_sums.pop_front());
                end
            end
            if (start && !busy)
                expected_sums.push_back(predict_sum(i_operand_a, i_operand_b, i_mode));
        end
    end

    assign pending = expected_sums.size();
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the binary32 add/sub unit
// ----------------------------------------------------------------------------
// Drives directed special operands (zeros, subnormals, infinities, NaNs,
// overflow, rounding ties, cancellation) and then random requests biased
// toward close exponents, in bursts with random gaps.
module testbench;
    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand_a;
    logic [31:0] i_operand_b;
    logic        i_mode;
    logic        o_valid;
    logic [31:0] o_result;
    int          fail_count;
    int          pending;
    int          cycle_count;

    localparam int RANDOM_REQUESTS = 450;
    localparam int CYCLE_LIMIT     = 200000;

    float32_add_sub_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    fas_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[float32_add_sub_unit] ERROR");
            $finish;
        end
    end

    function automatic logic [31:0] random_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v[30:23] = 8'h00;
            1: v[30:23] = 8'hFF;
            2: v[30:23] = 8'hFE;
            3: v[22:0] = 23'h0;
            default: ;
        endcase
        return v;
    endfunction

    // hold one request on the ports until it is accepted
    task automatic send_request(logic [31:0] a, logic [31:0] b, logic m);
        i_operand_a <= a;
        i_operand_b <= b;
        i_mode      <= m;
        start       <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a, b;
        int          burst;
        cycle_count = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operand_a = '0;
        i_operand_b = '0;
        i_mode      = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_request(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_request(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(32'h8000_0000, 32'h0000_0000, 1'b1);
        send_request(32'h3F80_0000, 32'h3F80_0000, 1'b1);
        send_request(32'h0000_0001, 32'h0000_0001, 1'b0);
        send_request(32'h007F_FFFF, 32'h0000_0001, 1'b0);
        send_request(32'h0080_0000, 32'h0000_0001, 1'b1);
        send_request(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
        send_request(32'h7F7F_FFFF, 32'h7380_0000, 1'b0);
        send_request(32'h7F80_0000, 32'h7F80_0000, 1'b1);
        send_request(32'h7F80_0000, 32'hFF80_0000, 1'b1);
        send_request(32'hFF80_0000, 32'h3F80_0000, 1'b0);
        send_request(32'h3F80_0000, 32'h7F80_0000, 1'b1);
        send_request(32'h7FC0_0000, 32'h3F80_0000, 1'b0);
        send_request(32'h3F80_0000, 32'hFF80_0001, 1'b1);
        send_request(32'h3F80_0000, 32'h3380_0000, 1'b0);
        send_request(32'h3F80_0001, 32'h3380_0000, 1'b0);
        send_request(32'h3F80_0000, 32'h0000_0001, 1'b1);
        send_request(32'h4B7F_FFFF, 32'h3F00_0000, 1'b0);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(32'h3F80_0000, 32'h3F7F_FFFF, 1'b1);
        idle_cycles(1);

        // sender pauses until everything is back
        while (pending != 0) @(posedge i_clk);

        // random, in bursts
        for (int n = 0; n < RANDOM_REQUESTS; ) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && n < RANDOM_REQUESTS; k++, n++) begin
                a = random_operand();
                b = random_operand();
                if ($urandom_range(0, 2) != 0)
                    b[30:23] = a[30:23] + 8'($urandom_range(0, 4)) - 8'd2;
                send_request(a, b, 1'($urandom));
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[float32_add_sub_unit] OK");
        else
            $display("[float32_add_sub_unit] ERROR");
        $finish;
    end
endmodule
